[hw/rtl/ptrd_pkg.sv]
// ----------------------------------------------------------------------------
// ptrd_pkg: shared types and constants of the packed texture record decoder
// Phase, result kind and error codes, register indexes, dictionary sizing and
// the result descriptor that travels from the control unit to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package ptrd_pkg;

  // Dictionary sizing
  localparam int DICT_DEPTH = 4096;
  localparam int DICT_AW    = $clog2(DICT_DEPTH);
  localparam int CNT_W      = $clog2(DICT_DEPTH + 1);

  // Marker of a packed record
  localparam logic [15:0] PACKED_MARK = 16'hFFFF;

  // Configuration register indexes
  localparam int          CFG_IDX_W      = 1;
  localparam logic [0:0]  REG_MAX_WIDTH  = 1'b0;
  localparam logic [0:0]  REG_MAX_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_ALPHA,
    PH_WIDTH,
    PH_HEIGHT,
    PH_COUNT,
    PH_DICT,
    PH_CODES,
    PH_RAW
  } phase_t;

  typedef enum logic [1:0] {
    KIND_INFO  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_SIZE = 2'd1,
    ERR_DICT = 2'd2,
    ERR_CODE = 2'd3
  } err_t;

  // Result descriptor between control and output stage
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        from_dict;  // pixel value comes from the dictionary read
    logic [15:0] raw_pix;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic        has_alpha;
    err_t        err;
    logic        last;
  } req_t;

endpackage

`default_nettype wire

[hw/rtl/ptrd_dict_ram.sv]
// ----------------------------------------------------------------------------
// ptrd_dict_ram: dictionary storage
// One write port, one read port with a registered read enabled by the
// pipeline advance. Contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrd_dict_ram
  import ptrd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [DICT_AW-1:0] waddr,
  input  wire logic [15:0]        wdata,
  input  wire logic               re,
  input  wire logic [DICT_AW-1:0] raddr,
  output logic      [15:0]        rdata
);

  logic [15:0] mem [DICT_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ptrd_ctrl.sv]
// ----------------------------------------------------------------------------
// ptrd_ctrl: record parser and bit-serial code unpacker
// Walks the record header, loads the dictionary, shifts packed code words one
// bit per unstalled cycle into the code register, issues result descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrd_ctrl
  import ptrd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [15:0]          in_record_word,
  // configuration writes
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  // pipeline advance from the output stage
  input  wire logic                 adv,
  // dictionary ports
  output logic                      mem_we,
  output logic [DICT_AW-1:0]        mem_waddr,
  output logic [15:0]               mem_wdata,
  output logic [DICT_AW-1:0]        mem_raddr,
  // result descriptor
  output req_t                      req
);

  // ceil(log2 cnt), at least 1
  function automatic logic [4:0] code_width_of(input logic [15:0] cnt);
    logic [15:0] m;
    logic [4:0]  cw;
    m  = cnt - 16'd1;
    cw = 5'd1;
    if (cnt > 16'd2) begin
      for (int i = 1; i < 16; i++) begin
        if (m[i]) cw = 5'(i + 1);
      end
    end
    return cw;
  endfunction

  phase_t             phase_r,  phase_nxt;
  logic               alpha_r,  alpha_nxt;
  logic               packed_r, packed_nxt;
  logic [15:0]        max_w_r,  max_w_nxt;
  logic [15:0]        max_h_r,  max_h_nxt;
  logic [15:0]        width_r,  width_nxt;
  logic [15:0]        col_r,    col_nxt;     // pixels left in the current row
  logic [15:0]        row_r,    row_nxt;     // rows left, current one included
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic [CNT_W-1:0]   fill_r,   fill_nxt;
  logic [4:0]         cw_r,     cw_nxt;
  logic [15:0]        part_r,   part_nxt;
  logic [4:0]         pbits_r,  pbits_nxt;
  logic [15:0]        sh_r,     sh_nxt;      // code word shift register
  logic [3:0]         bits_r,   bits_nxt;    // bits left in sh_r
  logic               busy_r,   busy_nxt;
  req_t               req_r,    req_nxt;

  logic               in_acc;
  logic               bit_go;
  logic               bit_in;
  logic [15:0]        part_ext;
  logic [4:0]         pbits_inc;
  logic               px_go;
  logic               px_last;
  logic [CNT_W-1:0]   fill_inc;

  assign in_ready = adv && !busy_r;
  assign in_acc   = in_valid && in_ready;
  assign bit_go   = adv && (busy_r || (in_acc && phase_r == PH_CODES));
  assign req      = req_r;

  // next state and descriptor
  always_comb begin
    phase_nxt  = phase_r;
    alpha_nxt  = alpha_r;
    packed_nxt = packed_r;
    max_w_nxt  = max_w_r;
    max_h_nxt  = max_h_r;
    width_nxt  = width_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    count_nxt  = count_r;
    fill_nxt   = fill_r;
    cw_nxt     = cw_r;
    part_nxt   = part_r;
    pbits_nxt  = pbits_r;
    sh_nxt     = sh_r;
    bits_nxt   = bits_r;
    busy_nxt   = busy_r;
    req_nxt    = req_r;

    bit_in    = busy_r ? sh_r[15] : in_record_word[15];
    part_ext  = {part_r[14:0], bit_in};
    pbits_inc = pbits_r + 5'd1;
    px_last   = (col_r == 16'd1) && (row_r == 16'd1);
    px_go     = 1'b0;
    fill_inc  = fill_r + CNT_W'(1);

    mem_we    = 1'b0;
    mem_waddr = fill_r[DICT_AW-1:0];
    mem_wdata = in_record_word;
    mem_raddr = part_ext[DICT_AW-1:0];

    if (adv) begin
      req_nxt           = '0;
      req_nxt.has_alpha = alpha_r;
    end

    // configuration registers
    if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_WIDTH:  max_w_nxt = cfg_data;
        REG_MAX_HEIGHT: max_h_nxt = cfg_data;
        default: ;
      endcase
    end

    // one word taken per accept
    if (in_acc) begin
      case (phase_r)
        PH_FIRST: begin
          if (in_record_word == PACKED_MARK) begin
            packed_nxt = 1'b1;
            phase_nxt  = PH_ALPHA;
          end else begin
            packed_nxt = 1'b0;
            alpha_nxt  = (in_record_word != 16'd0);
            phase_nxt  = PH_WIDTH;
          end
        end
        PH_ALPHA: begin
          alpha_nxt = (in_record_word != 16'd0);
          phase_nxt = PH_WIDTH;
        end
        PH_WIDTH: begin
          width_nxt = in_record_word;
          phase_nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          req_nxt.valid = 1'b1;
          if (width_r > max_w_r || in_record_word > max_h_r) begin
            req_nxt.kind = KIND_ERROR;
            req_nxt.err  = ERR_SIZE;
            req_nxt.last = 1'b1;
            phase_nxt    = PH_FIRST;
          end else begin
            req_nxt.kind  = KIND_INFO;
            req_nxt.img_w = width_r;
            req_nxt.img_h = in_record_word;
            col_nxt       = width_r;
            row_nxt       = in_record_word;
            if (width_r == 16'd0 || in_record_word == 16'd0) begin
              req_nxt.last = 1'b1;
              phase_nxt    = PH_FIRST;
            end else begin
              phase_nxt = packed_r ? PH_COUNT : PH_RAW;
            end
          end
        end
        PH_COUNT: begin
          count_nxt = CNT_W'(in_record_word);
          fill_nxt  = '0;
          part_nxt  = '0;
          pbits_nxt = '0;
          cw_nxt    = code_width_of(in_record_word);
          if (17'(in_record_word) > 17'(DICT_DEPTH)) begin
            req_nxt.valid = 1'b1;
            req_nxt.kind  = KIND_ERROR;
            req_nxt.err   = ERR_DICT;
            req_nxt.last  = 1'b1;
            phase_nxt     = PH_FIRST;
          end else begin
            phase_nxt = (in_record_word == 16'd0) ? PH_CODES : PH_DICT;
          end
        end
        PH_DICT: begin
          mem_we   = 1'b1;
          fill_nxt = fill_inc;
          if (fill_inc >= count_r) phase_nxt = PH_CODES;
        end
        PH_CODES: begin
          // first bit is taken straight from the port below
          sh_nxt   = {in_record_word[14:0], 1'b0};
          bits_nxt = 4'd15;
          busy_nxt = 1'b1;
        end
        PH_RAW: begin
          req_nxt.valid     = 1'b1;
          req_nxt.kind      = KIND_PIXEL;
          req_nxt.raw_pix   = in_record_word;
          px_go             = 1'b1;
        end
        default: ;
      endcase
    end

    // one code bit per cycle while the pipeline advances
    if (bit_go) begin
      if (busy_r) begin
        sh_nxt   = {sh_r[14:0], 1'b0};
        bits_nxt = bits_r - 4'd1;
        if (bits_r == 4'd1) busy_nxt = 1'b0;
      end
      if (pbits_inc == cw_r) begin
        part_nxt      = '0;
        pbits_nxt     = '0;
        req_nxt.valid = 1'b1;
        if (17'(part_ext) >= 17'(count_r)) begin
          req_nxt.kind = KIND_ERROR;
          req_nxt.err  = ERR_CODE;
          req_nxt.last = 1'b1;
          phase_nxt    = PH_FIRST;
          busy_nxt     = 1'b0;
        end else begin
          req_nxt.kind      = KIND_PIXEL;
          req_nxt.from_dict = 1'b1;
          px_go             = 1'b1;
          if (px_last) busy_nxt = 1'b0;
        end
      end else begin
        part_nxt  = part_ext;
        pbits_nxt = pbits_inc;
      end
    end

    // pixel countdown
    if (px_go) begin
      req_nxt.last = px_last;
      if (px_last) phase_nxt = PH_FIRST;
      if (col_r == 16'd1) begin
        col_nxt = width_r;
        row_nxt = row_r - 16'd1;
      end else begin
        col_nxt = col_r - 16'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      alpha_r  <= 1'b0;
      packed_r <= 1'b0;
      max_w_r  <= 16'd256;
      max_h_r  <= 16'd256;
      count_r  <= '0;
      fill_r   <= '0;
      cw_r     <= 5'd1;
      part_r   <= '0;
      pbits_r  <= '0;
      bits_r   <= '0;
      busy_r   <= 1'b0;
      req_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      alpha_r  <= alpha_nxt;
      packed_r <= packed_nxt;
      max_w_r  <= max_w_nxt;
      max_h_r  <= max_h_nxt;
      count_r  <= count_nxt;
      fill_r   <= fill_nxt;
      cw_r     <= cw_nxt;
      part_r   <= part_nxt;
      pbits_r  <= pbits_nxt;
      bits_r   <= bits_nxt;
      busy_r   <= busy_nxt;
      req_r    <= req_nxt;
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    sh_r    <= sh_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ptrd_expand.sv]
// ----------------------------------------------------------------------------
// ptrd_expand: pixel expansion and output register
// Picks the pixel from the dictionary read or the raw word, widens it to
// 8 bits per channel and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrd_expand
  import ptrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire req_t        req,
  input  wire logic [15:0] rd_data,
  output logic             adv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [15:0]      out_image_width,
  output logic [15:0]      out_image_height,
  output logic             out_has_alpha,
  output logic [1:0]       out_error_code,
  output logic             out_last
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  red_r, green_r, blue_r, alpha_r;
  logic [15:0] img_w_r, img_h_r;
  logic        has_alpha_r;
  logic [1:0]  err_r;
  logic        last_r;

  logic [15:0] pix;
  logic [7:0]  red_c, green_c, blue_c, alpha_c;

  assign adv = !valid_r || out_ready;

  // bit replication of ARGB4444 or RGB565
  always_comb begin
    pix     = req.from_dict ? rd_data : req.raw_pix;
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    alpha_c = '0;
    if (req.kind == KIND_PIXEL) begin
      if (req.has_alpha) begin
        red_c   = {pix[11:8], pix[11:8]};
        green_c = {pix[7:4], pix[7:4]};
        blue_c  = {pix[3:0], pix[3:0]};
        alpha_c = {pix[15:12], pix[15:12]};
      end else begin
        red_c   = {pix[15:11], pix[15:13]};
        green_c = {pix[10:5], pix[10:9]};
        blue_c  = {pix[4:0], pix[4:2]};
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= req.valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r      <= req.kind;
      red_r       <= red_c;
      green_r     <= green_c;
      blue_r      <= blue_c;
      alpha_r     <= alpha_c;
      img_w_r     <= req.img_w;
      img_h_r     <= req.img_h;
      has_alpha_r <= req.has_alpha;
      err_r       <= req.err;
      last_r      <= req.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_image_width  = img_w_r;
  assign out_image_height = img_h_r;
  assign out_has_alpha    = has_alpha_r;
  assign out_error_code   = err_r;
  assign out_last         = last_r;

endmodule

`default_nettype wire

[hw/rtl/packed_texture_record_decoder.sv]
// ----------------------------------------------------------------------------
// packed_texture_record_decoder: texture record to RGBA8 pixel decoder
// Parses plain and dictionary-packed texture records word by word and emits
// an info item, expanded pixels and error items.
// ----------------------------------------------------------------------------
// Header, count, dictionary and raw pixel words are taken one per cycle. A
// packed code word is unpacked one bit per cycle through a 16-bit shift
// register and holds the input until its bits are used up, the image ends
// or a bad code stops the record; each completed code makes one dictionary
// read and one pixel, or an error item when the code is out of range. A
// result passes through the descriptor register and the output register,
// and a stalled output holds the whole block. The dictionary is a 4096 x 16
// memory with no clearing pass, so the block is ready right after reset.
// Configuration writes are always taken and apply at the next height word.
`default_nettype none

module packed_texture_record_decoder
  import ptrd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [15:0]          in_record_word,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_red,
  output logic [7:0]                out_green,
  output logic [7:0]                out_blue,
  output logic [7:0]                out_alpha,
  output logic [15:0]               out_image_width,
  output logic [15:0]               out_image_height,
  output logic                      out_has_alpha,
  output logic [1:0]                out_error_code,
  output logic                      out_last,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  logic               adv;
  logic               mem_we;
  logic [DICT_AW-1:0] mem_waddr;
  logic [15:0]        mem_wdata;
  logic [DICT_AW-1:0] mem_raddr;
  logic [15:0]        mem_rdata;
  req_t               req;

  assign cfg_ready = 1'b1;

  // header parser and code unpacker
  ptrd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_record_word (in_record_word),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .adv            (adv),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_raddr      (mem_raddr),
    .req            (req)
  );

  // dictionary
  ptrd_dict_ram u_dict (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (adv),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // expansion and output register
  ptrd_expand u_expand (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (req),
    .rd_data          (mem_rdata),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_image_width  (out_image_width),
    .out_image_height (out_image_height),
    .out_has_alpha    (out_has_alpha),
    .out_error_code   (out_error_code),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/ptrd_checker.sv]
// ----------------------------------------------------------------------------
// ptrd_checker: port-level checks of the packed texture record decoder
// Watches the result channel for field consistency and a held stalled item.
// ----------------------------------------------------------------------------
`default_nettype none

module ptrd_checker
  import ptrd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           out_kind,
  input wire logic [7:0]           out_red,
  input wire logic [7:0]           out_green,
  input wire logic [7:0]           out_blue,
  input wire logic [7:0]           out_alpha,
  input wire logic [15:0]          out_image_width,
  input wire logic [15:0]          out_image_height,
  input wire logic                 out_has_alpha,
  input wire logic [1:0]           out_error_code,
  input wire logic                 out_last
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result item changed");

  // an error always closes the record
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |-> out_last && out_error_code != ERR_NONE)
    else $error("error item without last or code");

  // non-error items carry no error code
  a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ERROR |-> out_error_code == ERR_NONE)
    else $error("error code on a non-error item");

  // pixels carry no size; RGB565 pixels have zero alpha
  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PIXEL |->
      out_image_width == 16'd0 && out_image_height == 16'd0
      && (out_has_alpha || out_alpha == 8'd0))
    else $error("pixel item with stray fields");

endmodule

bind packed_texture_record_decoder ptrd_checker u_ptrd_checker (.*);

`default_nettype wire
